// File: hw/rtl/spq_pkg.sv
// Shared constants, types and register codes for the sphere point query block
package spq_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ROT_BITS   = 16;
    localparam int ROT_FRAC   = 14;
    localparam int ROW_W      = 3 * ROT_BITS;

    // transform datapath
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = DIFF_W + ROT_BITS;
    localparam int ACC_W  = PROD_W + 2;
    localparam int V_W    = ACC_W - ROT_FRAC;
    localparam int A_W    = 30;
    localparam int K_MAX  = V_W - A_W;
    localparam int K_W    = $clog2(K_MAX + 1);
    localparam int SQ_W   = 2 * A_W;
    localparam int SUM_W  = SQ_W + 2;

    // square root
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // surface divide
    localparam int Q_W    = ROT_FRAC + 1;
    localparam int NUM_W  = A_W + ROT_FRAC + 1;
    localparam int SURF_W = 16;

    // distance path
    localparam int SCALE_W  = 31;
    localparam int P_W      = ROOT_W + SCALE_W;
    localparam int R_W      = 32 + FRAC_BITS + 1;
    localparam int DD_W     = R_W + 1;
    localparam int LO_W     = 24;
    localparam int HI_W     = DD_W - LO_W;
    localparam int PL_W     = LO_W + SCALE_W;
    localparam int PH_W     = HI_W + SCALE_W + 1;
    localparam int FULL_W   = PH_W + LO_W + 1;
    localparam int DIST_W   = 32;
    localparam int UDIST_W  = 31;

    localparam logic [R_W-1:0] R_ONE = R_W'(1) << FRAC_BITS;
    localparam logic [R_W-1:0] R_CAP = R_W'(1) << (32 + FRAC_BITS);
    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    // pipeline latencies
    localparam int XF_LAT   = 8;
    localparam int DIV_LAT  = Q_W + 2;
    localparam int DIST_LAT = 6;
    localparam int DLY_LEN  = DIV_LAT - DIST_LAT;

    // configuration port
    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    typedef enum logic [2:0] {
        REG_CENTER_X      = 3'd0,
        REG_CENTER_Y      = 3'd1,
        REG_CENTER_Z      = 3'd2,
        REG_RADIUS_SCALE  = 3'd3,
        REG_INVERSE_SCALE = 3'd4,
        REG_ROT_ROW0      = 3'd5,
        REG_ROT_ROW1      = 3'd6,
        REG_ROT_ROW2      = 3'd7
    } cfg_reg_t;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
    localparam logic [ROW_W-1:0]   ROW0_RESET  = ROW_W'(16384);
    localparam logic [ROW_W-1:0]   ROW1_RESET  = ROW_W'(16384) << ROT_BITS;
    localparam logic [ROW_W-1:0]   ROW2_RESET  = ROW_W'(16384) << (2 * ROT_BITS);

    typedef struct packed {
        logic [2:0][A_W-1:0] a;
        logic [2:0]          neg;
        logic [K_W-1:0]      k;
    } side_t;

endpackage

// File: hw/rtl/spq_point_if.sv
// Query point channel: valid, ready and one point word
interface spq_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [spq_pkg::COORD_BITS-1:0] point_x;
    logic signed [spq_pkg::COORD_BITS-1:0] point_y;
    logic signed [spq_pkg::COORD_BITS-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// File: hw/rtl/spq_result_if.sv
// Query result channel: valid, ready and one result word
interface spq_result_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  is_inside;
    logic signed [spq_pkg::DIST_W-1:0]     signed_dist;
    logic [spq_pkg::UDIST_W-1:0]           unsigned_dist;
    logic signed [spq_pkg::SURF_W-1:0]     surface_x;
    logic signed [spq_pkg::SURF_W-1:0]     surface_y;
    logic signed [spq_pkg::SURF_W-1:0]     surface_z;

    modport source (output valid, is_inside, signed_dist, unsigned_dist,
                    surface_x, surface_y, surface_z, input ready);
    modport sink   (input valid, is_inside, signed_dist, unsigned_dist,
                    surface_x, surface_y, surface_z, output ready);
endinterface

// File: hw/rtl/spq_xform.sv
// Front pipeline: offset, rotate, normalize range and sum of squares
module spq_xform (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [spq_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [spq_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [spq_pkg::COORD_BITS-1:0] point_z,
    input  logic signed [spq_pkg::COORD_BITS-1:0] center_x,
    input  logic signed [spq_pkg::COORD_BITS-1:0] center_y,
    input  logic signed [spq_pkg::COORD_BITS-1:0] center_z,
    input  logic [spq_pkg::ROW_W-1:0]             rot_row0,
    input  logic [spq_pkg::ROW_W-1:0]             rot_row1,
    input  logic [spq_pkg::ROW_W-1:0]             rot_row2,
    output logic                                  out_valid,
    output logic [spq_pkg::SUM_W-1:0]             sum,
    output spq_pkg::side_t                        side
);

    logic [spq_pkg::XF_LAT-1:0] vld_reg;

    logic signed [spq_pkg::COORD_BITS-1:0] pt [3];
    logic signed [spq_pkg::COORD_BITS-1:0] ctr [3];
    logic [spq_pkg::ROW_W-1:0]             rot [3];

    logic signed [spq_pkg::DIFF_W-1:0] d_reg [3];
    logic signed [spq_pkg::DIFF_W-1:0] d_next [3];
    logic signed [spq_pkg::ROT_BITS-1:0] re [3][3];
    logic signed [spq_pkg::PROD_W-1:0] prod_reg [3][3];
    logic signed [spq_pkg::PROD_W-1:0] prod_next [3][3];
    logic signed [spq_pkg::ACC_W-1:0]  acc [3];
    logic signed [spq_pkg::V_W-1:0]    v_reg [3];
    logic signed [spq_pkg::V_W-1:0]    v_next [3];
    logic [spq_pkg::V_W-1:0]           mag4_reg [3];
    logic [spq_pkg::V_W-1:0]           mag4_next [3];
    logic [2:0]                        neg4_reg;
    logic [spq_pkg::V_W-1:0]           mag5_reg [3];
    logic [2:0]                        neg5_reg;
    logic [spq_pkg::V_W-1:0]           max01;
    logic [spq_pkg::V_W-1:0]           max5_reg;
    logic [spq_pkg::V_W-1:0]           max5_next;
    logic [spq_pkg::K_W-1:0]           k6;
    spq_pkg::side_t                    side6_reg;
    spq_pkg::side_t                    side6_next;
    logic [spq_pkg::SQ_W-1:0]          sq_reg [3];
    logic [spq_pkg::SQ_W-1:0]          sq_next [3];
    spq_pkg::side_t                    side7_reg;
    logic [spq_pkg::SUM_W-1:0]         sum_reg;
    logic [spq_pkg::SUM_W-1:0]         sum_next;
    spq_pkg::side_t                    side8_reg;

    always_comb
    begin
        pt  = '{point_x, point_y, point_z};
        ctr = '{center_x, center_y, center_z};
        rot = '{rot_row0, rot_row1, rot_row2};
        for (int i = 0; i < 3; i++)
        begin
            d_next[i] = spq_pkg::DIFF_W'(pt[i]) - spq_pkg::DIFF_W'(ctr[i]);
            for (int j = 0; j < 3; j++)
            begin
                re[i][j] = rot[i][spq_pkg::ROT_BITS*j +: spq_pkg::ROT_BITS];
                prod_next[i][j] = spq_pkg::PROD_W'(re[i][j]) * spq_pkg::PROD_W'(d_reg[i]);
            end
        end
        // column sums give the local vector; drop the rotation fraction (floor)
        for (int j = 0; j < 3; j++)
        begin
            acc[j] = spq_pkg::ACC_W'(prod_reg[0][j]) + spq_pkg::ACC_W'(prod_reg[1][j])
                   + spq_pkg::ACC_W'(prod_reg[2][j]);
            v_next[j] = acc[j][spq_pkg::ACC_W-1:spq_pkg::ROT_FRAC];
            mag4_next[j] = v_reg[j][spq_pkg::V_W-1] ? spq_pkg::V_W'(-v_reg[j])
                                                    : spq_pkg::V_W'(v_reg[j]);
        end
        max01 = (mag4_reg[0] > mag4_reg[1]) ? mag4_reg[0] : mag4_reg[1];
        max5_next = (max01 > mag4_reg[2]) ? max01 : mag4_reg[2];
        // least shift that brings the largest magnitude below 2^A_W
        k6 = spq_pkg::K_W'(spq_pkg::K_MAX);
        for (int kk = spq_pkg::K_MAX; kk >= 0; kk--)
        begin
            if ((max5_reg >> kk) < (spq_pkg::V_W'(1) << spq_pkg::A_W))
            begin
                k6 = spq_pkg::K_W'(kk);
            end
        end
        side6_next.k   = k6;
        side6_next.neg = neg5_reg;
        for (int j = 0; j < 3; j++)
        begin
            side6_next.a[j] = spq_pkg::A_W'(mag5_reg[j] >> k6);
            sq_next[j] = spq_pkg::SQ_W'(side6_reg.a[j]) * spq_pkg::SQ_W'(side6_reg.a[j]);
        end
        sum_next = spq_pkg::SUM_W'(sq_reg[0]) + spq_pkg::SUM_W'(sq_reg[1])
                 + spq_pkg::SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_next;
            prod_reg  <= prod_next;
            v_reg     <= v_next;
            mag4_reg  <= mag4_next;
            neg4_reg  <= {v_reg[2][spq_pkg::V_W-1], v_reg[1][spq_pkg::V_W-1],
                          v_reg[0][spq_pkg::V_W-1]};
            mag5_reg  <= mag4_reg;
            neg5_reg  <= neg4_reg;
            max5_reg  <= max5_next;
            side6_reg <= side6_next;
            sq_reg    <= sq_next;
            side7_reg <= side6_reg;
            sum_reg   <= sum_next;
            side8_reg <= side7_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[spq_pkg::XF_LAT-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[spq_pkg::XF_LAT-1];
    assign sum       = sum_reg;
    assign side      = side8_reg;

endmodule

// File: hw/rtl/spq_isqrt.sv
// Pipelined integer square root, one root bit per stage
module spq_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [spq_pkg::SUM_W-1:0]    radicand,
    input  spq_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic [spq_pkg::ROOT_W-1:0]   root,
    output spq_pkg::side_t               out_side
);

    logic                         vld_reg  [spq_pkg::ROOT_W];
    logic [spq_pkg::REM_W-1:0]    rem_reg  [spq_pkg::ROOT_W];
    logic [spq_pkg::ROOT_W-1:0]   root_reg [spq_pkg::ROOT_W];
    logic [spq_pkg::SUM_W-1:0]    x_reg    [spq_pkg::ROOT_W];
    spq_pkg::side_t               side_reg [spq_pkg::ROOT_W];

    for (genvar s = 0; s < spq_pkg::ROOT_W; s++)
    begin : g_stage
        logic                         vin;
        logic [spq_pkg::REM_W-1:0]    rem_in;
        logic [spq_pkg::ROOT_W-1:0]   root_in;
        logic [spq_pkg::SUM_W-1:0]    x_in;
        spq_pkg::side_t               side_in;
        logic [spq_pkg::REM_W+1:0]    rem_sh;
        logic [spq_pkg::REM_W+1:0]    trial;
        logic [spq_pkg::REM_W-1:0]    rem_next;
        logic [spq_pkg::ROOT_W-1:0]   root_next;

        if (s == 0)
        begin : g_first
            assign vin     = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = radicand;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign vin     = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign x_in    = x_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // bring down the next two radicand bits, try root*4+1
        always_comb
        begin
            rem_sh = {rem_in, x_in[spq_pkg::SUM_W-1 -: 2]};
            trial  = (spq_pkg::REM_W+2)'({root_in, 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next  = spq_pkg::REM_W'(rem_sh - trial);
                root_next = {root_in[spq_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = spq_pkg::REM_W'(rem_sh);
                root_next = {root_in[spq_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                x_reg[s]    <= {x_in[spq_pkg::SUM_W-3:0], 2'b00};
                side_reg[s] <= side_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vin;
            end
        end
    end

    assign out_valid = vld_reg[spq_pkg::ROOT_W-1];
    assign root      = root_reg[spq_pkg::ROOT_W-1];
    assign out_side  = side_reg[spq_pkg::ROOT_W-1];

endmodule

// File: hw/rtl/spq_div.sv
// Pipelined rounding divide for the surface point, one quotient bit per stage
module spq_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [spq_pkg::ROOT_W-1:0]         m,
    input  spq_pkg::side_t                     in_side,
    input  logic                               inv_zero,
    output logic                               out_valid,
    output logic signed [spq_pkg::SURF_W-1:0]  surface_x,
    output logic signed [spq_pkg::SURF_W-1:0]  surface_y,
    output logic signed [spq_pkg::SURF_W-1:0]  surface_z
);

    // setup stage
    logic                          vld0_reg;
    logic [spq_pkg::NUM_W-1:0]     num0_reg [3];
    logic [spq_pkg::NUM_W-1:0]     num0_next [3];
    logic [spq_pkg::ROOT_W-1:0]    m0_reg;
    logic [2:0]                    neg0_reg;
    logic                          zero0_reg;

    // quotient stages
    logic                          vld_reg  [spq_pkg::Q_W];
    logic [spq_pkg::NUM_W-1:0]     rem_reg  [spq_pkg::Q_W][3];
    logic [spq_pkg::Q_W-1:0]       q_reg    [spq_pkg::Q_W][3];
    logic [spq_pkg::ROOT_W-1:0]    m_reg    [spq_pkg::Q_W];
    logic [2:0]                    neg_reg  [spq_pkg::Q_W];
    logic                          zero_reg [spq_pkg::Q_W];

    // output stage
    logic                               vldo_reg;
    logic signed [spq_pkg::SURF_W-1:0]  surf_reg [3];
    logic signed [spq_pkg::SURF_W-1:0]  surf_next [3];

    // numerator a*2^14 + m/2 gives round to nearest
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            num0_next[j] = spq_pkg::NUM_W'({in_side.a[j], {spq_pkg::ROT_FRAC{1'b0}}})
                         + spq_pkg::NUM_W'(m >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num0_reg  <= num0_next;
            m0_reg    <= m;
            neg0_reg  <= in_side.neg;
            zero0_reg <= (m == '0) || inv_zero;
        end
    end

    for (genvar t = 0; t < spq_pkg::Q_W; t++)
    begin : g_step
        logic                          vin;
        logic [spq_pkg::NUM_W-1:0]     rem_in [3];
        logic [spq_pkg::Q_W-1:0]       q_in [3];
        logic [spq_pkg::ROOT_W-1:0]    m_in;
        logic [2:0]                    neg_in;
        logic                          zero_in;
        logic [spq_pkg::NUM_W-1:0]     dsh;
        logic [spq_pkg::NUM_W-1:0]     rem_next [3];
        logic [spq_pkg::Q_W-1:0]       q_next [3];

        if (t == 0)
        begin : g_first
            assign vin     = vld0_reg;
            assign rem_in  = num0_reg;
            assign q_in    = '{default: '0};
            assign m_in    = m0_reg;
            assign neg_in  = neg0_reg;
            assign zero_in = zero0_reg;
        end
        else
        begin : g_rest
            assign vin     = vld_reg[t-1];
            assign rem_in  = rem_reg[t-1];
            assign q_in    = q_reg[t-1];
            assign m_in    = m_reg[t-1];
            assign neg_in  = neg_reg[t-1];
            assign zero_in = zero_reg[t-1];
        end

        always_comb
        begin
            dsh = spq_pkg::NUM_W'(m_in) << (spq_pkg::Q_W - 1 - t);
            for (int j = 0; j < 3; j++)
            begin
                if (rem_in[j] >= dsh)
                begin
                    rem_next[j] = rem_in[j] - dsh;
                    q_next[j]   = {q_in[j][spq_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j] = rem_in[j];
                    q_next[j]   = {q_in[j][spq_pkg::Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[t]  <= rem_next;
                q_reg[t]    <= q_next;
                m_reg[t]    <= m_in;
                neg_reg[t]  <= neg_in;
                zero_reg[t] <= zero_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[t] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[t] <= vin;
            end
        end
    end

    // apply sign; a zero vector or a zero inverse scale gives a zero surface point
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (zero_reg[spq_pkg::Q_W-1])
            begin
                surf_next[j] = '0;
            end
            else if (neg_reg[spq_pkg::Q_W-1][j])
            begin
                surf_next[j] = -spq_pkg::SURF_W'(q_reg[spq_pkg::Q_W-1][j]);
            end
            else
            begin
                surf_next[j] = spq_pkg::SURF_W'(q_reg[spq_pkg::Q_W-1][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            surf_reg <= surf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vldo_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= in_valid;
            vldo_reg <= vld_reg[spq_pkg::Q_W-1];
        end
    end

    assign out_valid = vldo_reg;
    assign surface_x = surf_reg[0];
    assign surface_y = surf_reg[1];
    assign surface_z = surf_reg[2];

endmodule

// File: hw/rtl/spq_dist.sv
// Distance pipeline: local radius, scaled signed and unsigned distance
module spq_dist (
    input  logic                               clk,
    input  logic                               en,
    input  logic [spq_pkg::ROOT_W-1:0]         m,
    input  logic [spq_pkg::K_W-1:0]            k,
    input  logic [spq_pkg::SCALE_W-1:0]        inverse_scale,
    input  logic [spq_pkg::SCALE_W-1:0]        radius_scale,
    output logic                               is_inside,
    output logic signed [spq_pkg::DIST_W-1:0]  signed_dist,
    output logic [spq_pkg::UDIST_W-1:0]        unsigned_dist
);

    logic [spq_pkg::P_W-1:0]              p_reg;
    logic [spq_pkg::K_W-1:0]              k1_reg;
    logic [spq_pkg::P_W-1:0]              psh;
    logic [spq_pkg::R_W-1:0]              r_reg;
    logic [spq_pkg::R_W-1:0]              r_next;
    logic                                 in2_reg;
    logic signed [spq_pkg::DD_W-1:0]      diff_reg;
    logic                                 in3_reg;
    logic signed [spq_pkg::HI_W-1:0]      dh;
    logic [spq_pkg::LO_W-1:0]             dl;
    logic signed [spq_pkg::SCALE_W:0]     rs_s;
    logic signed [spq_pkg::PH_W-1:0]      ph_reg;
    logic [spq_pkg::PL_W-1:0]             pl_reg;
    logic                                 in4_reg;
    logic signed [spq_pkg::FULL_W-1:0]    full;
    logic signed [spq_pkg::FULL_W-1:0]    fsh;
    logic signed [spq_pkg::DIST_W-1:0]    sd_next;
    logic signed [spq_pkg::DIST_W-1:0]    sd5_reg;
    logic                                 in5_reg;
    logic [spq_pkg::UDIST_W-1:0]          ud_next;
    logic signed [spq_pkg::DIST_W-1:0]    sd6_reg;
    logic [spq_pkg::UDIST_W-1:0]          ud6_reg;
    logic                                 in6_reg;

    logic                                 dly_in [spq_pkg::DLY_LEN];
    logic signed [spq_pkg::DIST_W-1:0]    dly_sd [spq_pkg::DLY_LEN];
    logic [spq_pkg::UDIST_W-1:0]          dly_ud [spq_pkg::DLY_LEN];

    always_comb
    begin
        // r = m * inverse_scale * 2^k / 2^F, capped
        psh = p_reg >> (spq_pkg::FRAC_BITS - int'(k1_reg));
        if (psh > spq_pkg::P_W'(spq_pkg::R_CAP))
        begin
            r_next = spq_pkg::R_CAP;
        end
        else
        begin
            r_next = spq_pkg::R_W'(psh);
        end

        // split the difference so each product stays narrow
        dh   = diff_reg[spq_pkg::DD_W-1:spq_pkg::LO_W];
        dl   = diff_reg[spq_pkg::LO_W-1:0];
        rs_s = {1'b0, radius_scale};

        full = (spq_pkg::FULL_W'(ph_reg) <<< spq_pkg::LO_W) + spq_pkg::FULL_W'(pl_reg);
        fsh  = full >>> spq_pkg::FRAC_BITS;
        if (fsh > spq_pkg::FULL_W'(spq_pkg::DIST_MAX))
        begin
            sd_next = spq_pkg::DIST_MAX;
        end
        else if (fsh < spq_pkg::FULL_W'(spq_pkg::DIST_MIN))
        begin
            sd_next = spq_pkg::DIST_MIN;
        end
        else
        begin
            sd_next = spq_pkg::DIST_W'(fsh);
        end

        if (sd5_reg == spq_pkg::DIST_MIN)
        begin
            ud_next = spq_pkg::UDIST_W'(spq_pkg::DIST_MAX);
        end
        else if (sd5_reg[spq_pkg::DIST_W-1])
        begin
            ud_next = spq_pkg::UDIST_W'(-sd5_reg);
        end
        else
        begin
            ud_next = spq_pkg::UDIST_W'(sd5_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= spq_pkg::P_W'(m) * spq_pkg::P_W'(inverse_scale);
            k1_reg   <= k;
            r_reg    <= r_next;
            in2_reg  <= psh < spq_pkg::P_W'(spq_pkg::R_ONE);
            diff_reg <= spq_pkg::DD_W'(r_reg) - spq_pkg::DD_W'(spq_pkg::R_ONE);
            in3_reg  <= in2_reg;
            ph_reg   <= spq_pkg::PH_W'(dh) * spq_pkg::PH_W'(rs_s);
            pl_reg   <= spq_pkg::PL_W'(dl) * spq_pkg::PL_W'(radius_scale);
            in4_reg  <= in3_reg;
            sd5_reg  <= sd_next;
            in5_reg  <= in4_reg;
            sd6_reg  <= sd5_reg;
            ud6_reg  <= ud_next;
            in6_reg  <= in5_reg;

            // hold results in step with the surface divide
            dly_in[0] <= in6_reg;
            dly_sd[0] <= sd6_reg;
            dly_ud[0] <= ud6_reg;
            for (int i = 1; i < spq_pkg::DLY_LEN; i++)
            begin
                dly_in[i] <= dly_in[i-1];
                dly_sd[i] <= dly_sd[i-1];
                dly_ud[i] <= dly_ud[i-1];
            end
        end
    end

    assign is_inside     = dly_in[spq_pkg::DLY_LEN-1];
    assign signed_dist   = dly_sd[spq_pkg::DLY_LEN-1];
    assign unsigned_dist = dly_ud[spq_pkg::DLY_LEN-1];

endmodule

// File: hw/rtl/sphere_point_query.sv
// Path from an accepted point word to its result word: 8 transform, 31 square root
// and 17 surface divide stages.
// Throughput: one point word per cycle; the whole pipeline holds while a result
// word waits at the output and the sink is not ready.
// Reset clears all valid bits and loads a unit sphere at the origin, identity rotation.
// Top level: configuration registers, pipeline control and result output
module sphere_point_query (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spq_pkg::CFG_AW-1:0]    paddr,
    input  logic [spq_pkg::CFG_DW-1:0]    pwdata,
    output logic [spq_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready,
    spq_point_if.sink                     pt,
    spq_result_if.source                  res
);

    logic signed [spq_pkg::COORD_BITS-1:0] center_x_reg;
    logic signed [spq_pkg::COORD_BITS-1:0] center_y_reg;
    logic signed [spq_pkg::COORD_BITS-1:0] center_z_reg;
    logic [spq_pkg::SCALE_W-1:0]           radius_scale_reg;
    logic [spq_pkg::SCALE_W-1:0]           inverse_scale_reg;
    logic [spq_pkg::ROW_W-1:0]             rot_row0_reg;
    logic [spq_pkg::ROW_W-1:0]             rot_row1_reg;
    logic [spq_pkg::ROW_W-1:0]             rot_row2_reg;

    spq_pkg::cfg_reg_t cfg_idx;
    logic              cfg_wr;
    logic              en;
    logic              out_valid;

    logic                          xf_valid;
    logic [spq_pkg::SUM_W-1:0]     xf_sum;
    spq_pkg::side_t                xf_side;
    logic                          sq_valid;
    logic [spq_pkg::ROOT_W-1:0]    sq_root;
    spq_pkg::side_t                sq_side;

    assign cfg_idx = spq_pkg::cfg_reg_t'(paddr[spq_pkg::CFG_AW-1:3]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            center_z_reg      <= '0;
            radius_scale_reg  <= spq_pkg::SCALE_RESET;
            inverse_scale_reg <= spq_pkg::SCALE_RESET;
            rot_row0_reg      <= spq_pkg::ROW0_RESET;
            rot_row1_reg      <= spq_pkg::ROW1_RESET;
            rot_row2_reg      <= spq_pkg::ROW2_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                spq_pkg::REG_CENTER_X:      center_x_reg <= pwdata[spq_pkg::COORD_BITS-1:0];
                spq_pkg::REG_CENTER_Y:      center_y_reg <= pwdata[spq_pkg::COORD_BITS-1:0];
                spq_pkg::REG_CENTER_Z:      center_z_reg <= pwdata[spq_pkg::COORD_BITS-1:0];
                spq_pkg::REG_RADIUS_SCALE:  radius_scale_reg <= pwdata[spq_pkg::SCALE_W-1:0];
                spq_pkg::REG_INVERSE_SCALE: inverse_scale_reg <= pwdata[spq_pkg::SCALE_W-1:0];
                spq_pkg::REG_ROT_ROW0:      rot_row0_reg <= pwdata[spq_pkg::ROW_W-1:0];
                spq_pkg::REG_ROT_ROW1:      rot_row1_reg <= pwdata[spq_pkg::ROW_W-1:0];
                spq_pkg::REG_ROT_ROW2:      rot_row2_reg <= pwdata[spq_pkg::ROW_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            spq_pkg::REG_CENTER_X:      prdata = spq_pkg::CFG_DW'(unsigned'(center_x_reg));
            spq_pkg::REG_CENTER_Y:      prdata = spq_pkg::CFG_DW'(unsigned'(center_y_reg));
            spq_pkg::REG_CENTER_Z:      prdata = spq_pkg::CFG_DW'(unsigned'(center_z_reg));
            spq_pkg::REG_RADIUS_SCALE:  prdata = spq_pkg::CFG_DW'(radius_scale_reg);
            spq_pkg::REG_INVERSE_SCALE: prdata = spq_pkg::CFG_DW'(inverse_scale_reg);
            spq_pkg::REG_ROT_ROW0:      prdata = spq_pkg::CFG_DW'(rot_row0_reg);
            spq_pkg::REG_ROT_ROW1:      prdata = spq_pkg::CFG_DW'(rot_row1_reg);
            spq_pkg::REG_ROT_ROW2:      prdata = spq_pkg::CFG_DW'(rot_row2_reg);
        endcase
    end

    // advance every stage unless a finished word is blocked at the output
    assign en       = !out_valid || res.ready;
    assign pt.ready = en;

    spq_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pt.valid),
        .point_x   (pt.point_x),
        .point_y   (pt.point_y),
        .point_z   (pt.point_z),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .rot_row0  (rot_row0_reg),
        .rot_row1  (rot_row1_reg),
        .rot_row2  (rot_row2_reg),
        .out_valid (xf_valid),
        .sum       (xf_sum),
        .side      (xf_side)
    );

    spq_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xf_valid),
        .radicand  (xf_sum),
        .in_side   (xf_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    spq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .m         (sq_root),
        .in_side   (sq_side),
        .inv_zero  (inverse_scale_reg == '0),
        .out_valid (out_valid),
        .surface_x (res.surface_x),
        .surface_y (res.surface_y),
        .surface_z (res.surface_z)
    );

    spq_dist u_dist (
        .clk           (clk),
        .en            (en),
        .m             (sq_root),
        .k             (sq_side.k),
        .inverse_scale (inverse_scale_reg),
        .radius_scale  (radius_scale_reg),
        .is_inside     (res.is_inside),
        .signed_dist   (res.signed_dist),
        .unsigned_dist (res.unsigned_dist)
    );

    assign res.valid = out_valid;

endmodule
